// File: hdl/console_command_parser_defines.svh
// ----------------------------------------------------------------------------
// Console command parser assertion macros
// Shared property wrappers for the parser's concurrent checks.
// ----------------------------------------------------------------------------
`ifndef CONSOLE_COMMAND_PARSER_DEFINES_SVH
`define CONSOLE_COMMAND_PARSER_DEFINES_SVH

// Check that cons holds in the same cycle as ante.
`define CCP_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Check that cons holds in the cycle after ante.
`define CCP_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: hdl/ccp_pkg.sv
// ----------------------------------------------------------------------------
// Console command parser package
// Grammar phases, command kinds, keyword tables and character classes.
// ----------------------------------------------------------------------------
package ccp_pkg;

   // Position in the command grammar
   typedef enum logic [2:0] {
      PH_CMD  = 3'd0,
      PH_WS1  = 3'd1,
      PH_NUM1 = 3'd2,
      PH_WS2  = 3'd3,
      PH_NUM2 = 3'd4,
      PH_WS3  = 3'd5,
      PH_MODE = 3'd6,
      PH_TAIL = 3'd7
   } phase_type;

   // Result kinds
   typedef enum logic [2:0] {
      KIND_SPEED = 3'd0,
      KIND_REV   = 3'd1,
      KIND_SW    = 3'd2,
      KIND_LIGHT = 3'd3,
      KIND_GO    = 3'd4,
      KIND_STOP  = 3'd5,
      KIND_QUIT  = 3'd6,
      KIND_ERROR = 3'd7
   } kind_type;

   localparam int unsigned CMD_COUNT  = 7;
   localparam int unsigned MODE_COUNT = 4;
   localparam int unsigned WORD_MAX   = 5;

   localparam logic [7:0] NUL = 8'h00;

   // Command keywords, one row per kind code
   localparam logic [7:0] CMD_WORDS [CMD_COUNT][WORD_MAX] = '{
      '{"t", "r", NUL, NUL, NUL},
      '{"r", "v", NUL, NUL, NUL},
      '{"s", "w", NUL, NUL, NUL},
      '{"l", "i", "g", "h", "t"},
      '{"g", "o", NUL, NUL, NUL},
      '{"s", "t", "o", "p", NUL},
      '{"q", NUL, NUL, NUL, NUL}
   };
   localparam logic [2:0] CMD_LENS [CMD_COUNT] = '{3'd2, 3'd2, 3'd2, 3'd5, 3'd2, 3'd4, 3'd1};

   // Mode words: straight, curved, on, off
   localparam logic [7:0] MODE_WORDS [MODE_COUNT][WORD_MAX] = '{
      '{"S", NUL, NUL, NUL, NUL},
      '{"C", NUL, NUL, NUL, NUL},
      '{"o", "n", NUL, NUL, NUL},
      '{"o", "f", "f", NUL, NUL}
   };
   localparam logic [2:0] MODE_LENS [MODE_COUNT] = '{3'd1, 3'd1, 3'd2, 3'd3};
   localparam logic [MODE_COUNT-1:0] MODE_FLAGS = 4'b0110;

   localparam logic [CMD_COUNT-1:0] CMD_CAND_ALL  = 7'h7F;
   localparam logic [CMD_COUNT-1:0] MODE_CAND_ALL = 7'h0F;

   function automatic logic is_space(input logic [7:0] c);
      return (c == 8'd32) || (c >= 8'd9 && c <= 8'd13);
   endfunction

   function automatic logic is_digit(input logic [7:0] c);
      return (c >= "0") && (c <= "9");
   endfunction

   function automatic logic is_alnum(input logic [7:0] c);
      return is_digit(c) || (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
   endfunction

   // Keywords whose character at position len matches c
   function automatic logic [CMD_COUNT-1:0] cmd_keep(input logic [2:0] len,
                                                     input logic [7:0] c);
      logic [CMD_COUNT-1:0] keep;
      keep = '0;
      if (len < 3'd5) begin
         for (int k = 0; k < CMD_COUNT; k++) begin
            keep[k] = (CMD_WORDS[k][len] == c);
         end
      end
      return keep;
   endfunction

   function automatic logic [MODE_COUNT-1:0] mode_keep(input logic [2:0] len,
                                                       input logic [7:0] c);
      logic [MODE_COUNT-1:0] keep;
      keep = '0;
      if (len < 3'd5) begin
         for (int k = 0; k < MODE_COUNT; k++) begin
            keep[k] = (MODE_WORDS[k][len] == c);
         end
      end
      return keep;
   endfunction

   // First surviving keyword of the right length, else error
   function automatic kind_type cmd_resolve(input logic [CMD_COUNT-1:0] cand,
                                            input logic [2:0] len);
      kind_type kind;
      kind = KIND_ERROR;
      for (int k = CMD_COUNT - 1; k >= 0; k--) begin
         if (cand[k] && CMD_LENS[k] == len) begin
            kind = kind_type'(k[2:0]);
         end
      end
      return kind;
   endfunction

   // Mode match as {valid, flag}; the word must suit the command
   function automatic logic [1:0] mode_resolve(input logic [CMD_COUNT-1:0] cand,
                                               input logic [2:0] len,
                                               input kind_type code);
      logic       hit;
      logic [1:0] idx;
      hit = 1'b0;
      idx = 2'd0;
      for (int k = MODE_COUNT - 1; k >= 0; k--) begin
         if (cand[k] && MODE_LENS[k] == len) begin
            hit = 1'b1;
            idx = k[1:0];
         end
      end
      if (!hit) begin
         return 2'b00;
      end
      if (code == KIND_SW && idx > 2'd1) begin
         return 2'b00;
      end
      if (code == KIND_LIGHT && idx < 2'd2) begin
         return 2'b00;
      end
      return {1'b1, MODE_FLAGS[idx]};
   endfunction

endpackage

// File: hdl/console_command_parser.sv
// ----------------------------------------------------------------------------
// Console command parser
// Parses a zero-terminated command line, one character per word, into one
// command result with kind, two numbers and a mode flag.
// ----------------------------------------------------------------------------
// One character is taken every clock cycle unless the input side stalls. A
// character is held in the input register, then a single parse step updates
// the grammar state; for a zero byte that step loads the result register.
// The parse step (keyword compare and one multiply-by-ten with saturation)
// sets the cycle time. The input side stalls only while a result waits and a
// terminator is next in line. Non-terminator characters never produce a
// result. No clearing is needed after reset.
`include "console_command_parser_defines.svh"

module console_command_parser #(
   parameter int unsigned NUMBER_WIDTH = 16
) (
   input  logic                                         clock,
   input  logic                                         reset,
   // char_code [7:0]
   input  logic [7:0]                                   req_tdata,
   input  logic                                         req_tvalid,
   output logic                                         req_tready,
   // command_kind [2:0], first_value, second_value, mode_flag, zero fill
   output logic [((4 + 2 * NUMBER_WIDTH + 7) / 8) * 8 - 1:0] rsp_tdata,
   output logic                                         rsp_tvalid,
   input  logic                                         rsp_tready
);
   import ccp_pkg::*;

   localparam int unsigned W        = NUMBER_WIDTH;
   localparam int unsigned RSP_BITS = 4 + 2 * W;
   localparam int unsigned RSP_W    = ((RSP_BITS + 7) / 8) * 8;

   // Input register
   logic       in_valid_ff, in_valid_in;
   logic [7:0] char_ff, char_in;

   // Grammar state
   phase_type            phase_ff, phase_in;
   logic [2:0]           wl_ff, wl_in;
   logic [CMD_COUNT-1:0] cand_ff, cand_in;
   kind_type             code_ff, code_in;
   logic [W-1:0]         num1_ff, num1_in;
   logic [W-1:0]         num2_ff, num2_in;
   logic [1:0]           mm_ff, mm_in;

   // Result register
   logic          rsp_valid_ff, rsp_valid_in;
   kind_type      kind_ff, kind_in;
   logic [W-1:0]  v1_ff, v1_in;
   logic [W-1:0]  v2_ff, v2_in;
   logic          flag_ff, flag_in;

   logic proc;
   logic term;
   logic accept;

   // Multiply by ten, add a digit, saturate to the number width
   function automatic logic [W-1:0] add_digit(input logic [W-1:0] n, input logic [7:0] c);
      logic [W+3:0] v;
      v = {3'b000, n, 1'b0} + {1'b0, n, 3'b000} + {{W{1'b0}}, c[3:0]};
      if (v[W+3:W] != 4'd0) begin
         return '1;
      end
      return v[W-1:0];
   endfunction

   // Handshake: a terminator waits while the result register is full and not taken
   assign term       = (char_ff == NUL);
   assign proc       = in_valid_ff && (!term || !rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || proc;
   assign accept     = req_tvalid && req_tready;

   // Load the input register
   always_comb begin
      in_valid_in = in_valid_ff;
      char_in     = char_ff;
      if (accept) begin
         in_valid_in = 1'b1;
         char_in     = req_tdata;
      end else if (proc) begin
         in_valid_in = 1'b0;
      end
   end

   // Next grammar state: walk the phases in order until the character is used
   always_comb begin
      logic done;
      logic sp;
      logic dg;
      logic an;
      phase_in = phase_ff;
      wl_in    = wl_ff;
      cand_in  = cand_ff;
      code_in  = code_ff;
      num1_in  = num1_ff;
      num2_in  = num2_ff;
      mm_in    = mm_ff;
      done     = 1'b0;
      sp       = is_space(char_ff);
      dg       = is_digit(char_ff);
      an       = is_alnum(char_ff);
      if (proc) begin
         if (term) begin
            phase_in = PH_CMD;
            wl_in    = 3'd0;
            cand_in  = CMD_CAND_ALL;
            code_in  = KIND_SPEED;
            num1_in  = '0;
            num2_in  = '0;
            mm_in    = 2'b00;
         end else begin
            if (phase_in == PH_CMD) begin
               done = 1'b1;
               if (an) begin
                  cand_in = cand_in & cmd_keep(wl_in, char_ff);
                  if (wl_in < 3'd7) begin
                     wl_in = wl_in + 3'd1;
                  end
               end else if (sp) begin
                  code_in  = cmd_resolve(cand_in, wl_in);
                  phase_in = (code_in <= KIND_LIGHT) ? PH_WS1 : PH_TAIL;
               end
            end
            if (!done && phase_in == PH_WS1) begin
               if (sp) begin
                  done = 1'b1;
               end else begin
                  phase_in = PH_NUM1;
               end
            end
            if (!done && phase_in == PH_NUM1) begin
               if (dg) begin
                  num1_in = add_digit(num1_in, char_ff);
                  done    = 1'b1;
               end else if (code_in == KIND_SPEED) begin
                  phase_in = PH_WS2;
               end else if (code_in == KIND_REV) begin
                  phase_in = PH_TAIL;
                  done     = 1'b1;
               end else begin
                  phase_in = PH_WS3;
                  wl_in    = 3'd0;
                  cand_in  = MODE_CAND_ALL;
               end
            end
            if (!done && phase_in == PH_WS2) begin
               if (sp) begin
                  done = 1'b1;
               end else begin
                  phase_in = PH_NUM2;
               end
            end
            if (!done && phase_in == PH_NUM2) begin
               done = 1'b1;
               if (dg) begin
                  num2_in = add_digit(num2_in, char_ff);
               end else begin
                  phase_in = PH_TAIL;
               end
            end
            if (!done && phase_in == PH_WS3) begin
               if (sp) begin
                  done = 1'b1;
               end else begin
                  phase_in = PH_MODE;
               end
            end
            if (!done && phase_in == PH_MODE) begin
               if (an) begin
                  cand_in = cand_in & {3'b000, mode_keep(wl_in, char_ff)};
                  if (wl_in < 3'd7) begin
                     wl_in = wl_in + 3'd1;
                  end
               end else if (sp) begin
                  mm_in    = mode_resolve(cand_in, wl_in, code_in);
                  phase_in = PH_TAIL;
               end
            end
         end
      end
   end

   // Result fields from the state left at the terminator
   always_comb begin
      kind_type   code_e;
      logic [1:0] m;
      rsp_valid_in = rsp_valid_ff;
      kind_in      = kind_ff;
      v1_in        = v1_ff;
      v2_in        = v2_ff;
      flag_in      = flag_ff;
      code_e = (phase_ff == PH_CMD) ? cmd_resolve(cand_ff, wl_ff) : code_ff;
      if (phase_ff == PH_MODE) begin
         m = mode_resolve(cand_ff, wl_ff, code_ff);
      end else if (phase_ff == PH_TAIL) begin
         m = mm_ff;
      end else begin
         m = 2'b00;
      end
      if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (proc && term) begin
         rsp_valid_in = 1'b1;
         kind_in      = code_e;
         v1_in        = '0;
         v2_in        = '0;
         flag_in      = 1'b0;
         case (code_e) inside
            KIND_SPEED: begin
               v1_in = num1_ff;
               v2_in = num2_ff;
            end
            KIND_REV: begin
               v1_in = num1_ff;
            end
            KIND_SW, KIND_LIGHT: begin
               if (m[1]) begin
                  v1_in   = num1_ff;
                  flag_in = m[0];
               end else begin
                  kind_in = KIND_ERROR;
               end
            end
            default: begin
            end
         endcase
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         phase_ff     <= PH_CMD;
         wl_ff        <= 3'd0;
         cand_ff      <= CMD_CAND_ALL;
         code_ff      <= KIND_SPEED;
         num1_ff      <= '0;
         num2_ff      <= '0;
         mm_ff        <= 2'b00;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         phase_ff     <= phase_in;
         wl_ff        <= wl_in;
         cand_ff      <= cand_in;
         code_ff      <= code_in;
         num1_ff      <= num1_in;
         num2_ff      <= num2_in;
         mm_ff        <= mm_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      char_ff <= char_in;
      kind_ff <= kind_in;
      v1_ff   <= v1_in;
      v2_ff   <= v2_in;
      flag_ff <= flag_in;
   end

   // Pack the result word, zero-extended to whole bytes
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_W'({flag_ff, v2_ff, v1_ff, kind_ff});

   `CCP_ASSERT_NEXT(a_term_clears, clock, reset, proc && term,
      phase_ff == PH_CMD && cand_ff == CMD_CAND_ALL && wl_ff == 3'd0,
      "grammar state not cleared after terminator")

   `CCP_ASSERT_SAME(a_rsp_from_term, clock, reset, $rose(rsp_valid_ff),
      $past(proc && term), "result raised without a terminator")

   `CCP_ASSERT_SAME(a_mode_cand, clock, reset, phase_ff == PH_WS3 || phase_ff == PH_MODE,
      cand_ff[CMD_COUNT-1:MODE_COUNT] == 3'b000, "command candidates leaked into mode word")

   `CCP_ASSERT_SAME(a_error_zero, clock, reset, rsp_valid_ff && kind_ff == KIND_ERROR,
      v1_ff == '0 && v2_ff == '0 && !flag_ff, "error result carries data")

   `CCP_ASSERT_NEXT(a_char_held, clock, reset, in_valid_ff && !proc,
      in_valid_ff && $stable(char_ff), "pending character lost")

endmodule

// File: sim/tb.sv
// ----------------------------------------------------------------------------
// Console command parser testbench
// Feeds zero-terminated command lines one character at a time and checks
// each parsed result against a cycle-free model of the command grammar.
// Directed lines cover every keyword and the odd corners of the grammar.
// Random lines follow the grammar with mangled content, mixed with noise.
// Both sides of the stream idle at random, and the result side also holds
// off for a long stretch.
// ----------------------------------------------------------------------------
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import ccp_pkg::*;

   localparam int RSP_BITS     = 40;
   localparam int HOLD_CYCLES  = 300;
   localparam int TARGET_CHARS = 1900;
   localparam int STEADY_CHARS = 250;

   typedef struct {
      kind_type    kind;
      logic [15:0] first_value;
      logic [15:0] second_value;
      logic        mode_flag;
   } parse_result_type;

   logic                clock = 1'b0;
   logic                reset;
   logic [7:0]          req_tdata;
   logic                req_tvalid;
   logic                req_tready;
   logic [RSP_BITS-1:0] rsp_tdata;
   logic                rsp_tvalid;
   logic                rsp_tready;

   parse_result_type pending_results[$];
   logic [7:0]    line_buf[$];
   int            chars_sent  = 0;
   int            error_count = 0;
   bit            steady_flow = 1'b0;
   bit            hold_request = 1'b0;

   // Grammar state of the model
   phase_type   phase;
   logic [2:0]  word_len;
   logic [6:0]  candidates;
   kind_type    cmd_kind;
   logic [15:0] arg_one;
   logic [15:0] arg_two;
   logic [1:0]  mode_hit;

   console_command_parser u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // ------------------------------------------------------------------
   // Character classes and keyword tables
   // ------------------------------------------------------------------
   function automatic bit char_is_space(logic [7:0] c);
      return c == 8'd32 || (c >= 8'd9 && c <= 8'd13);
   endfunction

   function automatic bit char_is_digit(logic [7:0] c);
      return c >= 8'd48 && c <= 8'd57;
   endfunction

   function automatic bit char_is_alnum(logic [7:0] c);
      return char_is_digit(c) || (c >= 8'd65 && c <= 8'd90) || (c >= 8'd97 && c <= 8'd122);
   endfunction

   // Command keywords in kind order
   function automatic string keyword_text(int k);
      case (k)
         0: return "tr";
         1: return "rv";
         2: return "sw";
         3: return "light";
         4: return "go";
         5: return "stop";
         default: return "q";
      endcase
   endfunction

   // Mode words: straight, curved, on, off
   function automatic string mode_text(int k);
      case (k)
         0: return "S";
         1: return "C";
         2: return "on";
         default: return "off";
      endcase
   endfunction

   // ------------------------------------------------------------------
   // Grammar model
   // ------------------------------------------------------------------
   function automatic void clear_parser();
      phase      = PH_CMD;
      word_len   = 3'd0;
      candidates = 7'h7F;
      cmd_kind   = KIND_SPEED;
      arg_one    = 16'd0;
      arg_two    = 16'd0;
      mode_hit   = 2'b00;
   endfunction

   function automatic logic [15:0] shift_in_digit(logic [15:0] n, logic [7:0] c);
      int unsigned v;
      v = int'(n) * 10 + int'(c) - 48;
      return (v > 65535) ? 16'hFFFF : v[15:0];
   endfunction

   // Drop candidates whose letter at the current position differs
   function automatic void push_letter(logic [7:0] c, bit mode_word);
      logic [6:0] keep;
      string      w;
      keep = '0;
      if (word_len < 3'd5) begin
         for (int k = 0; k < (mode_word ? 4 : 7); k++) begin
            w = mode_word ? mode_text(k) : keyword_text(k);
            if (int'(word_len) < w.len() && w[word_len] == c) keep[k] = 1'b1;
         end
      end
      candidates = candidates & keep;
      if (word_len < 3'd7) word_len = word_len + 3'd1;
   endfunction

   function automatic int match_word(bit mode_word);
      string w;
      for (int k = 0; k < (mode_word ? 4 : 7); k++) begin
         w = mode_word ? mode_text(k) : keyword_text(k);
         if (candidates[k] && w.len() == int'(word_len)) return k;
      end
      return -1;
   endfunction

   function automatic void close_command_word();
      int k;
      k = match_word(1'b0);
      cmd_kind = (k < 0) ? KIND_ERROR : kind_type'(k[2:0]);
   endfunction

   // {valid, flag}; the mode word must suit the command
   function automatic logic [1:0] mode_result();
      int m;
      m = match_word(1'b1);
      if (m < 0) return 2'b00;
      if (cmd_kind == KIND_SW && m > 1) return 2'b00;
      if (cmd_kind == KIND_LIGHT && m < 2) return 2'b00;
      return {1'b1, (m == 1 || m == 2)};
   endfunction

   // Advance the grammar by one non-terminator character
   function automatic void advance_parser(logic [7:0] c);
      bit again;
      again = 1'b1;
      while (again) begin
         again = 1'b0;
         case (phase)
            PH_CMD: begin
               if (char_is_alnum(c)) begin
                  push_letter(c, 1'b0);
               end else if (char_is_space(c)) begin
                  close_command_word();
                  phase = (cmd_kind <= KIND_LIGHT) ? PH_WS1 : PH_TAIL;
               end
            end
            PH_WS1: begin
               if (!char_is_space(c)) begin
                  phase = PH_NUM1;
                  again = 1'b1;
               end
            end
            PH_NUM1: begin
               if (char_is_digit(c)) begin
                  arg_one = shift_in_digit(arg_one, c);
               end else begin
                  again = 1'b1;
                  if (cmd_kind == KIND_SPEED) begin
                     phase = PH_WS2;
                  end else if (cmd_kind == KIND_REV) begin
                     phase = PH_TAIL;
                  end else begin
                     phase      = PH_WS3;
                     word_len   = 3'd0;
                     candidates = 7'h0F;
                  end
               end
            end
            PH_WS2: begin
               if (!char_is_space(c)) begin
                  phase = PH_NUM2;
                  again = 1'b1;
               end
            end
            PH_NUM2: begin
               if (char_is_digit(c)) arg_two = shift_in_digit(arg_two, c);
               else phase = PH_TAIL;
            end
            PH_WS3: begin
               if (!char_is_space(c)) begin
                  phase = PH_MODE;
                  again = 1'b1;
               end
            end
            PH_MODE: begin
               if (char_is_alnum(c)) begin
                  push_letter(c, 1'b1);
               end else if (char_is_space(c)) begin
                  mode_hit = mode_result();
                  phase    = PH_TAIL;
               end
            end
            default: ;
         endcase
      end
   endfunction

   // Build the result for a terminator and restart the grammar
   function automatic parse_result_type finish_command();
      parse_result_type r;
      logic [1:0]    m;
      if (phase == PH_CMD) close_command_word();
      r.kind         = cmd_kind;
      r.first_value  = 16'd0;
      r.second_value = 16'd0;
      r.mode_flag    = 1'b0;
      case (cmd_kind) inside
         KIND_SPEED: begin
            r.first_value  = arg_one;
            r.second_value = arg_two;
         end
         KIND_REV: r.first_value = arg_one;
         KIND_SW, KIND_LIGHT: begin
            m = 2'b00;
            if (phase == PH_MODE) m = mode_result();
            else if (phase == PH_TAIL) m = mode_hit;
            if (m[1]) begin
               r.first_value = arg_one;
               r.mode_flag   = m[0];
            end else begin
               r.kind = KIND_ERROR;
            end
         end
         default: ;
      endcase
      clear_parser();
      return r;
   endfunction

   // ------------------------------------------------------------------
   // Line builders
   // ------------------------------------------------------------------
   function automatic logic [7:0] pick_space();
      logic [7:0] c;
      c = 8'($urandom_range(8, 13));
      return (c == 8'd8) ? 8'd32 : c;
   endfunction

   function automatic logic [7:0] pick_alnum();
      int n;
      n = $urandom_range(0, 61);
      if (n < 10) return 8'(48 + n);
      if (n < 36) return 8'(65 + n - 10);
      return 8'(97 + n - 36);
   endfunction

   // Any non-zero byte that is neither a letter, a digit nor whitespace
   function automatic logic [7:0] pick_junk();
      logic [7:0] c;
      do c = 8'($urandom_range(1, 255));
      while (char_is_alnum(c) || char_is_space(c));
      return c;
   endfunction

   function automatic void put_spaces();
      repeat ($urandom_range(1, 3)) line_buf.push_back(pick_space());
   endfunction

   // Word with the odd junk byte or wrong letter mixed in
   function automatic void put_word(string w);
      logic [7:0] c;
      for (int i = 0; i < w.len(); i++) begin
         if ($urandom_range(0, 99) < 6) line_buf.push_back(pick_junk());
         c = w[i];
         if ($urandom_range(0, 99) < 3) c = pick_alnum();
         line_buf.push_back(c);
      end
   endfunction

   // Mostly short numbers, some long enough to saturate, some missing
   function automatic void put_number();
      int r;
      int n;
      r = $urandom_range(0, 99);
      n = (r < 8) ? 0 : (r < 18) ? $urandom_range(6, 8) : $urandom_range(1, 5);
      repeat (n) line_buf.push_back(8'(48 + $urandom_range(0, 9)));
   endfunction

   function automatic void build_command();
      int sel;
      int k;
      int r;
      line_buf.delete();
      sel = $urandom_range(0, 99);
      if (sel < 8) begin
         // raw noise
         repeat ($urandom_range(0, 10)) line_buf.push_back(8'($urandom_range(1, 255)));
      end else begin
         k = (sel < 14) ? 7 : $urandom_range(0, 6);
         if (k == 7) repeat ($urandom_range(1, 7)) line_buf.push_back(pick_alnum());
         else put_word(keyword_text(k));
         if (k <= 3 && $urandom_range(0, 99) < 94) begin
            put_spaces();
            put_number();
            if (k == 0 && $urandom_range(0, 99) < 90) begin
               put_spaces();
               put_number();
            end
            if (k == 2 || k == 3) begin
               if ($urandom_range(0, 99) < 85) put_spaces();
               r = $urandom_range(0, 99);
               if (r < 75) begin
                  put_word(mode_text(k == 2 ? $urandom_range(0, 1) : $urandom_range(2, 3)));
               end else if (r < 90) begin
                  put_word(mode_text($urandom_range(0, 3)));
               end else begin
                  repeat ($urandom_range(0, 4)) line_buf.push_back(pick_alnum());
               end
            end
         end
         if ($urandom_range(0, 99) < 25) begin
            put_spaces();
            repeat ($urandom_range(1, 6)) line_buf.push_back(8'($urandom_range(1, 255)));
         end
      end
      line_buf.push_back(8'd0);
   endfunction

   // ------------------------------------------------------------------
   // Stream drivers
   // ------------------------------------------------------------------
   // Offer one input word, predict on acceptance
   task automatic send_char(logic [7:0] c);
      while (!steady_flow && $urandom_range(0, 99) < 25) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tdata  <= c;
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      chars_sent++;
      if (c == 8'd0) pending_results.push_back(finish_command());
      else advance_parser(c);
      @(negedge clock);
   endtask

   task automatic send_line();
      foreach (line_buf[i]) send_char(line_buf[i]);
   endtask

   task automatic send_text(string s);
      line_buf.delete();
      for (int i = 0; i < s.len(); i++) line_buf.push_back(s[i]);
      line_buf.push_back(8'd0);
      send_line();
   endtask

   // Stop offering and wait until every predicted result is out
   task automatic wait_for_results();
      req_tvalid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (8) @(negedge clock);
   endtask

   // Result side: random stalls, or a long hold-off on request
   initial begin
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            rsp_tready <= 1'b0;
            for (int n = 0; n < HOLD_CYCLES; n++) @(negedge clock);
         end else begin
            rsp_tready <= steady_flow || ($urandom_range(0, 99) >= 25);
         end
      end
   end

   // Compare each accepted result word with the oldest prediction
   always @(posedge clock) begin
      parse_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_results.size() == 0) begin
            $error("result word with none expected: %h", rsp_tdata);
            error_count++;
         end else begin
            want = pending_results.pop_front();
            if (rsp_tdata[2:0] !== want.kind) begin
               $error("command_kind: expected %0d, got %0d", want.kind, rsp_tdata[2:0]);
               error_count++;
            end
            if (rsp_tdata[18:3] !== want.first_value) begin
               $error("first_value: expected %0d, got %0d", want.first_value,
                      rsp_tdata[18:3]);
               error_count++;
            end
            if (rsp_tdata[34:19] !== want.second_value) begin
               $error("second_value: expected %0d, got %0d", want.second_value,
                      rsp_tdata[34:19]);
               error_count++;
            end
            if (rsp_tdata[35] !== want.mode_flag) begin
               $error("mode_flag: expected %0d, got %0d", want.mode_flag, rsp_tdata[35]);
               error_count++;
            end
            if (rsp_tdata[39:36] !== 4'd0) begin
               $error("zero fill: expected 0, got %0h", rsp_tdata[39:36]);
               error_count++;
            end
         end
      end
   end

   // ------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------
   task automatic test_keywords();
      send_text("tr 12 34");
      send_text("rv 7");
      send_text("sw 3 S");
      send_text("sw 4 C");
      send_text("light 1 on");
      send_text("light 2 off");
      send_text("go");
      send_text("stop");
      send_text("q");
   endtask

   task automatic test_special_cases();
      // empty line, and leading whitespace of every kind
      send_text("");
      send_text("\011\012\013\014\015 tr 1 2");
      // junk inside a word, unknown word, wrong case, over-long word
      send_text("t-r 5 6");
      send_text("tx 1");
      send_text("Go");
      send_text("lighter 1 on");
      // saturation and missing numbers
      send_text("tr 99999 1234567");
      send_text("tr 65535 65536");
      send_text("tr");
      send_text("rv x9");
      // number running straight into the mode word; missing or wrong mode
      send_text("sw 5C");
      send_text("sw 5");
      send_text("sw 5 on");
      send_text("light 3 S");
      // ignored tail and high bytes
      send_text("q extra 12 words");
      send_text("g\377o");
      send_text("\200q");
   endtask

   // Stall the result side while short lines keep coming, then drain
   task automatic test_backpressure();
      steady_flow  = 1'b1;
      hold_request = 1'b1;
      for (int i = 0; i < 40; i++) begin
         if (i % 2 == 0) send_text("q");
         else send_text("go");
      end
      wait_for_results();
      steady_flow = 1'b0;
   endtask

   task automatic test_random_commands();
      int start;
      start = chars_sent;
      steady_flow = 1'b1;
      while (chars_sent < TARGET_CHARS) begin
         if (chars_sent - start >= STEADY_CHARS) steady_flow = 1'b0;
         build_command();
         send_line();
      end
      steady_flow = 1'b0;
   endtask

   initial begin
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = 8'd0;
      clear_parser();
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      test_keywords();
      test_special_cases();
      test_backpressure();
      test_random_commands();
      wait_for_results();
      if (error_count == 0) begin
         $display("console_command_parser regression: pass");
      end else begin
         $display("console_command_parser regression: fail");
      end
      $finish;
   end

   // Guard against a hung handshake
   initial begin
      #200000;
      $display("console_command_parser regression: fail");
      $finish;
   end

endmodule

// File: files.f
+incdir+hdl
hdl/ccp_pkg.sv
hdl/console_command_parser.sv
sim/tb.sv
